FILE: src/rvr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvr_pkg
// Shared constants, payload types and the arctangent table for the rope
// pair rotation pipeline.
// ----------------------------------------------------------------------------
package rvr_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int STAGE_W       = (CORDIC_STAGES > 1) ? $clog2(CORDIC_STAGES) : 1;

    localparam int VEC_W   = 16;
    localparam int POS_W   = 16;
    localparam int ANGLE_W = 32;
    localparam int CW      = 34;            // cordic x / y, Q2.30 plus headroom
    localparam int ZW      = 32;            // residual angle, signed
    localparam int PW      = CW + VEC_W;    // one product
    localparam int SW      = PW + 1;        // sum of two products
    localparam int FRAC_SHIFT = 30;
    localparam int QW      = SW - FRAC_SHIFT;

    localparam logic signed [CW-1:0] INV_GAIN    = CW'(64'sd652032874);
    localparam logic [ANGLE_W-1:0]   EIGHTH_TURN = 32'h2000_0000;
    localparam logic signed [ZW-1:0] RES_OFFSET  = ZW'(64'sd536870912);
    localparam logic signed [SW-1:0] ROUND_BIAS  = SW'(64'sd536870912);
    localparam logic signed [QW-1:0] Q_MAX       = QW'(32'sd32767);
    localparam logic signed [QW-1:0] Q_MIN       = QW'(-32'sd32768);

    localparam logic [1:0] QUAD_0   = 2'd0;
    localparam logic [1:0] QUAD_90  = 2'd1;
    localparam logic [1:0] QUAD_180 = 2'd2;
    localparam logic [1:0] QUAD_270 = 2'd3;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic [1:0]              quad;
        logic signed [CW-1:0]    x;
        logic signed [CW-1:0]    y;
        logic signed [ZW-1:0]    z;
    } cordic_data_t;

    typedef struct packed {
        logic signed [PW-1:0] xc;
        logic signed [PW-1:0] ys;
        logic signed [PW-1:0] xs;
        logic signed [PW-1:0] yc;
    } product_data_t;

    typedef struct packed {
        logic signed [VEC_W-1:0] rot_x;
        logic signed [VEC_W-1:0] rot_y;
        logic                    clipped;
    } result_t;

    // atan(2^-i) as a fraction of a full turn, 2^32 units per turn
    function automatic logic [ZW-1:0] atan_turn(input int i);
        logic [ZW-1:0] v;
        begin
            unique case (i)
                0:  v = 32'd536870912;
                1:  v = 32'd316933406;
                2:  v = 32'd167458907;
                3:  v = 32'd85004756;
                4:  v = 32'd42667331;
                5:  v = 32'd21354465;
                6:  v = 32'd10679838;
                7:  v = 32'd5340245;
                8:  v = 32'd2670163;
                9:  v = 32'd1335087;
                10: v = 32'd667544;
                11: v = 32'd333772;
                12: v = 32'd166886;
                13: v = 32'd83443;
                14: v = 32'd41721;
                15: v = 32'd20861;
                16: v = 32'd10430;
                17: v = 32'd5215;
                18: v = 32'd2608;
                19: v = 32'd1304;
                20: v = 32'd652;
                21: v = 32'd326;
                22: v = 32'd163;
                23: v = 32'd81;
                24: v = 32'd41;
                25: v = 32'd20;
                26: v = 32'd10;
                27: v = 32'd5;
                28: v = 32'd3;
                29: v = 32'd1;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

FILE: src/rvr_angle_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvr_angle_cell
// Forms the rotation angle position * angle_step (mod one turn) and splits it
// into a quadrant and a residual that seeds the cordic chain.
// ----------------------------------------------------------------------------
module rvr_angle_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [rvr_pkg::ANGLE_W-1:0]        angle_step,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [rvr_pkg::VEC_W-1:0]   vec_x,
    input  logic signed [rvr_pkg::VEC_W-1:0]   vec_y,
    input  logic [rvr_pkg::POS_W-1:0]          position,
    output logic                               out_valid,
    input  logic                               out_ready,
    output rvr_pkg::cordic_data_t              out_data
);
    import rvr_pkg::*;

    logic                    valid_reg;
    logic signed [VEC_W-1:0] vx_reg;
    logic signed [VEC_W-1:0] vy_reg;
    logic [ANGLE_W-1:0]      angle_reg;
    logic [ANGLE_W-1:0]      angle_next;
    logic [ANGLE_W-1:0]      shifted;

    assign in_ready   = !valid_reg || out_ready;
    // product wraps modulo one turn
    assign angle_next = ANGLE_W'(position * angle_step);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            vx_reg    <= vec_x;
            vy_reg    <= vec_y;
            angle_reg <= angle_next;
        end
    end

    // quadrant applied exactly later, residual in [-1/8, 1/8) turn
    assign shifted = angle_reg + EIGHTH_TURN;

    always_comb
    begin
        out_data.vx   = vx_reg;
        out_data.vy   = vy_reg;
        out_data.quad = shifted[ANGLE_W-1:ANGLE_W-2];
        out_data.x    = INV_GAIN;
        out_data.y    = '0;
        out_data.z    = signed'({2'b00, shifted[ANGLE_W-3:0]}) - RES_OFFSET;
    end

    assign out_valid = valid_reg;

endmodule

FILE: src/rvr_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvr_cordic_cell
// One cordic rotation step; the stage index sets the shift and the table
// entry, and is tied to a constant by the instantiating chain.
// ----------------------------------------------------------------------------
module rvr_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [rvr_pkg::STAGE_W-1:0]   stage,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  rvr_pkg::cordic_data_t         in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output rvr_pkg::cordic_data_t         out_data
);
    import rvr_pkg::*;

    logic                 valid_reg;
    cordic_data_t         data_reg;
    cordic_data_t         data_next;
    logic signed [CW-1:0] x_in;
    logic signed [CW-1:0] y_in;
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic signed [ZW-1:0] z_in;
    logic signed [ZW-1:0] atan;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        x_in = in_data.x;
        y_in = in_data.y;
        z_in = in_data.z;
        x_sh = x_in >>> stage;
        y_sh = y_in >>> stage;
        atan = signed'(atan_turn(int'(stage)));
        data_next = in_data;
        if (z_in >= 0)
        begin
            data_next.x = x_in - y_sh;
            data_next.y = y_in + x_sh;
            data_next.z = z_in - atan;
        end
        else
        begin
            data_next.x = x_in + y_sh;
            data_next.y = y_in - x_sh;
            data_next.z = z_in + atan;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/rvr_product_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvr_product_cell
// Applies the quadrant to cosine and sine and forms the four products of
// the pair with the rotation.
// ----------------------------------------------------------------------------
module rvr_product_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rvr_pkg::cordic_data_t   in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rvr_pkg::product_data_t  out_data
);
    import rvr_pkg::*;

    logic                    valid_reg;
    product_data_t           data_reg;
    product_data_t           data_next;
    logic signed [CW-1:0]    x_in;
    logic signed [CW-1:0]    y_in;
    logic signed [CW-1:0]    cos_v;
    logic signed [CW-1:0]    sin_v;
    logic signed [VEC_W-1:0] vx;
    logic signed [VEC_W-1:0] vy;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        x_in = in_data.x;
        y_in = in_data.y;
        vx   = in_data.vx;
        vy   = in_data.vy;
        unique case (in_data.quad)
            QUAD_0:
            begin
                cos_v = x_in;
                sin_v = y_in;
            end
            QUAD_90:
            begin
                cos_v = -y_in;
                sin_v = x_in;
            end
            QUAD_180:
            begin
                cos_v = -x_in;
                sin_v = -y_in;
            end
            default:
            begin
                cos_v = y_in;
                sin_v = -x_in;
            end
        endcase
        data_next.xc = PW'(vx) * PW'(cos_v);
        data_next.ys = PW'(vy) * PW'(sin_v);
        data_next.xs = PW'(vx) * PW'(sin_v);
        data_next.yc = PW'(vy) * PW'(cos_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/rvr_round_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvr_round_cell
// Sums the products, rounds Q.41 to Q4.11 half up and saturates to 16 bits.
// Its register is the output register of the block.
// ----------------------------------------------------------------------------
module rvr_round_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  rvr_pkg::product_data_t  in_data,
    output logic                    out_valid,
    input  logic                    out_ready,
    output rvr_pkg::result_t        out_data
);
    import rvr_pkg::*;

    logic                 valid_reg;
    result_t              data_reg;
    result_t              data_next;
    logic signed [SW-1:0] sum_x;
    logic signed [SW-1:0] sum_y;
    logic signed [QW-1:0] q_x;
    logic signed [QW-1:0] q_y;
    logic                 clip_x;
    logic                 clip_y;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        sum_x  = SW'(in_data.xc) - SW'(in_data.ys) + ROUND_BIAS;
        sum_y  = SW'(in_data.xs) + SW'(in_data.yc) + ROUND_BIAS;
        q_x    = sum_x[SW-1:FRAC_SHIFT];
        q_y    = sum_y[SW-1:FRAC_SHIFT];
        clip_x = (q_x > Q_MAX) || (q_x < Q_MIN);
        clip_y = (q_y > Q_MAX) || (q_y < Q_MIN);
        priority if (q_x > Q_MAX)
            data_next.rot_x = VEC_W'(Q_MAX);
        else if (q_x < Q_MIN)
            data_next.rot_x = VEC_W'(Q_MIN);
        else
            data_next.rot_x = VEC_W'(q_x);
        priority if (q_y > Q_MAX)
            data_next.rot_y = VEC_W'(Q_MAX);
        else if (q_y < Q_MIN)
            data_next.rot_y = VEC_W'(Q_MIN);
        else
            data_next.rot_y = VEC_W'(q_y);
        data_next.clipped = clip_x || clip_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

FILE: src/rope_vector_rotate_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_vector_rotate_top
// Rotary position embedding for one pair: rotates (vec_x, vec_y) by
// position * angle_step through a chain of cordic cells.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+-----------------------------
//  cfg      | cfg_valid / cfg_ready | cfg_data (angle_step)
//  in       | in_valid / in_ready   | vec_x, vec_y, position
//  out      | out_valid / out_ready | rot_x, rot_y, clipped
//
//  one pair per cycle when out_ready holds; registered cells in order (angle multiply,
//  one cell per cordic stage, product cell, round cell)
//  every cell holds one transfer and takes a new one whenever it is empty or
//  its neighbor takes its content, so bubbles collapse under output stalls
//  rst_n clears all valid flags and angle_step; cfg_ready is always high
// ----------------------------------------------------------------------------
module rope_vector_rotate_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rvr_pkg::ANGLE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [rvr_pkg::VEC_W-1:0]    vec_x,
    input  logic signed [rvr_pkg::VEC_W-1:0]    vec_y,
    input  logic [rvr_pkg::POS_W-1:0]           position,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [rvr_pkg::VEC_W-1:0]    rot_x,
    output logic signed [rvr_pkg::VEC_W-1:0]    rot_y,
    output logic                                clipped
);
    import rvr_pkg::*;

    logic [ANGLE_W-1:0] angle_step_reg;

    logic          chain_valid [0:CORDIC_STAGES];
    logic          chain_ready [0:CORDIC_STAGES];
    cordic_data_t  chain_data  [0:CORDIC_STAGES];

    logic          prod_valid;
    logic          prod_ready;
    product_data_t prod_data;
    result_t       result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_step_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            angle_step_reg <= cfg_data;
        end
    end

    rvr_angle_cell u_angle (
        .clk        (clk),
        .rst_n      (rst_n),
        .angle_step (angle_step_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .vec_x      (vec_x),
        .vec_y      (vec_y),
        .position   (position),
        .out_valid  (chain_valid[0]),
        .out_ready  (chain_ready[0]),
        .out_data   (chain_data[0])
    );

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_cordic
        rvr_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (STAGE_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_data   (chain_data[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_data  (chain_data[k+1])
        );
    end

    rvr_product_cell u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (chain_ready[CORDIC_STAGES]),
        .in_data   (chain_data[CORDIC_STAGES]),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_data  (prod_data)
    );

    rvr_round_cell u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_data   (prod_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (result)
    );

    assign rot_x   = result.rot_x;
    assign rot_y   = result.rot_y;
    assign clipped = result.clipped;

    // a clipped result sits on a rail
    a_clip_on_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && clipped |->
            (rot_x == 16'sh7fff) || (rot_x == -16'sh8000) ||
            (rot_y == 16'sh7fff) || (rot_y == -16'sh8000))
        else $error("clipped set without a saturated component");

    // an accepted pair always lands in the angle cell
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> chain_valid[0])
        else $error("accepted pair lost at the angle cell");

    // a full first cordic cell that is not drained keeps the angle cell full
    a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
        chain_valid[0] && !chain_ready[0] |=> chain_valid[0])
        else $error("stalled pair dropped at the head of the chain");

    // a config transfer is visible in the next cycle
    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> angle_step_reg == $past(cfg_data))
        else $error("angle_step write not taken");

endmodule

FILE: tb/rope_vector_rotate_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_vector_rotate_checker
// Watches the config, input and output channels of the pair rotation block.
// Keeps its own copy of angle_step and predicts each rotated pair from it.
// Compares every output transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module rope_vector_rotate_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [rvr_pkg::ANGLE_W-1:0]         cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [rvr_pkg::VEC_W-1:0]    vec_x,
    input  logic signed [rvr_pkg::VEC_W-1:0]    vec_y,
    input  logic [rvr_pkg::POS_W-1:0]           position,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [rvr_pkg::VEC_W-1:0]    rot_x,
    input  logic signed [rvr_pkg::VEC_W-1:0]    rot_y,
    input  logic                                clipped,
    output int                                  mismatches,
    output int                                  outstanding
);

    // stages past the table would rotate by zero
    localparam int STAGES = (rvr_pkg::CORDIC_STAGES < 30) ? rvr_pkg::CORDIC_STAGES : 30;
    localparam longint INV_GAIN_Q30 = 64'sd652032874;
    localparam longint HALF_Q30     = 64'sd536870912;
    localparam logic [31:0] EIGHTH_TURN = 32'h2000_0000;

    longint atan_turns [30] = '{
        536870912, 316933406, 167458907, 85004756, 42667331,
        21354465, 10679838, 5340245, 2670163, 1335087,
        667544, 333772, 166886, 83443, 41721,
        20861, 10430, 5215, 2608, 1304,
        652, 326, 163, 81, 41,
        20, 10, 5, 3, 1
    };

    logic [rvr_pkg::ANGLE_W-1:0] step_model;
    rvr_pkg::result_t            pending_rot[$];
    int                          err_count;

    function automatic logic signed [15:0] round_q11(input longint acc, inout bit sat);
        longint r;
        begin
            // ties go toward plus infinity
            r = (acc + HALF_Q30) >>> 30;
            if (r > 32767) begin
                sat = 1'b1;
                return 16'sh7FFF;
            end
            if (r < -32768) begin
                sat = 1'b1;
                return 16'sh8000;
            end
            return r[15:0];
        end
    endfunction

    function automatic rvr_pkg::result_t rotate_pair(
        input logic signed [15:0] vx,
        input logic signed [15:0] vy,
        input logic [15:0]        pos,
        input logic [31:0]        step
    );
        logic [47:0]      turn_prod;
        logic [31:0]      angle;
        logic [1:0]       quad;
        longint           cx, cy, z, nx, c, s;
        bit               sat;
        rvr_pkg::result_t res;
        begin
            turn_prod = pos * step;
            // shift by an eighth turn so the quadrant rounds to nearest
            angle = turn_prod[31:0] + EIGHTH_TURN;
            quad  = angle[31:30];
            z     = longint'(angle[29:0]) - HALF_Q30;
            cx    = INV_GAIN_Q30;
            cy    = 0;
            for (int i = 0; i < STAGES; i++) begin
                if (z >= 0) begin
                    nx = cx - (cy >>> i);
                    cy = cy + (cx >>> i);
                    z  = z - atan_turns[i];
                end
                else begin
                    nx = cx + (cy >>> i);
                    cy = cy - (cx >>> i);
                    z  = z + atan_turns[i];
                end
                cx = nx;
            end
            case (quad)
                rvr_pkg::QUAD_0:
                begin
                    c = cx;
                    s = cy;
                end
                rvr_pkg::QUAD_90:
                begin
                    c = -cy;
                    s = cx;
                end
                rvr_pkg::QUAD_180:
                begin
                    c = -cx;
                    s = -cy;
                end
                default:
                begin
                    c = cy;
                    s = -cx;
                end
            endcase
            sat = 1'b0;
            res.rot_x   = round_q11(longint'(vx) * c - longint'(vy) * s, sat);
            res.rot_y   = round_q11(longint'(vx) * s + longint'(vy) * c, sat);
            res.clipped = sat;
            return res;
        end
    endfunction

    always @(posedge clk)
    begin
        rvr_pkg::result_t want;
        bit               bad;
        if (!rst_n)
        begin
            step_model = '0;
            pending_rot.delete();
            err_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_rot.size() == 0)
                begin
                    $error("output transfer with nothing pending: rot_x %0d rot_y %0d clipped %0d",
                           rot_x, rot_y, clipped);
                    err_count++;
                end
                else
                begin
                    want = pending_rot.pop_front();
                    bad  = 1'b0;
                    if (rot_x !== want.rot_x)
                    begin
                        $error("rot_x mismatch: expected %0d, actual %0d", want.rot_x, rot_x);
                        bad = 1'b1;
                    end
                    if (rot_y !== want.rot_y)
                    begin
                        $error("rot_y mismatch: expected %0d, actual %0d", want.rot_y, rot_y);
                        bad = 1'b1;
                    end
                    if (clipped !== want.clipped)
                    begin
                        $error("clipped mismatch: expected %0d, actual %0d",
                               want.clipped, clipped);
                        bad = 1'b1;
                    end
                    if (bad)
                        err_count++;
                end
            end
            // a pair accepted together with a config write still sees the old step
            if (in_valid && in_ready)
                pending_rot.push_back(rotate_pair(vec_x, vec_y, position, step_model));
            if (cfg_valid && cfg_ready)
                step_model = cfg_data;
        end
        mismatches  <= err_count;
        outstanding <= pending_rot.size();
    end

endmodule

FILE: tb/rope_vector_rotate_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rope_vector_rotate_top_tb
// Drives pairs and angle steps into the rope pair rotation block under
// varying sender gaps and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module rope_vector_rotate_top_tb;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 200;
    localparam int ITEMS_PER_PHASE = 170;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [rvr_pkg::ANGLE_W-1:0]         cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [rvr_pkg::VEC_W-1:0]    vec_x;
    logic signed [rvr_pkg::VEC_W-1:0]    vec_y;
    logic [rvr_pkg::POS_W-1:0]           position;
    logic                                out_valid;
    logic                                out_ready;
    logic signed [rvr_pkg::VEC_W-1:0]    rot_x;
    logic signed [rvr_pkg::VEC_W-1:0]    rot_y;
    logic                                clipped;

    int mismatches;
    int outstanding;
    int idle_pct;
    int stall_pct;
    bit hold_go;
    bit hold_done;

    rope_vector_rotate_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .position  (position),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .clipped   (clipped)
    );

    rope_vector_rotate_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .vec_x       (vec_x),
        .vec_y       (vec_y),
        .position    (position),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rot_x       (rot_x),
        .rot_y       (rot_y),
        .clipped     (clipped),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // receiver side: random stalls, plus one long hold-off on request
    initial
    begin
        int held;
        held      = 0;
        out_ready = 1'b0;
        hold_done = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_go && !hold_done)
            begin
                out_ready = 1'b0;
                held++;
                if (held >= HOLD_CYCLES)
                    hold_done = 1'b1;
            end
            else
                out_ready = ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $error("no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_pair(input logic [15:0] vx, input logic [15:0] vy,
                             input logic [15:0] pos);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        vec_x    = vx;
        vec_y    = vy;
        position = pos;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_step(input logic [31:0] step);
        cfg_valid = 1'b1;
        cfg_data  = step;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [15:0] pick_component();
        logic [15:0] v;
        begin
            case ($urandom_range(9))
                0:
                begin
                    case ($urandom_range(4))
                        0: v = 16'h7FFF;
                        1: v = 16'h8000;
                        2: v = 16'h0000;
                        3: v = 16'hFFFF;
                        default: v = 16'h0001;
                    endcase
                end
                1: v = ($urandom_range(1) != 0) ? 16'($urandom_range(4095))
                                                : -16'($urandom_range(4095));
                default: v = 16'($urandom);
            endcase
            return v;
        end
    endfunction

    function automatic logic [15:0] pick_position();
        begin
            if ($urandom_range(4) == 0)
                return 16'($urandom_range(64));
            return 16'($urandom);
        end
    endfunction

    initial
    begin
        int idle_tab [4];
        int stall_tab [4];
        logic [31:0] step;
        idle_tab  = '{0, 49, 0, 12};
        stall_tab = '{0, 0, 49, 12};
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        vec_x     = '0;
        vec_y     = '0;
        position  = '0;
        idle_pct  = 0;
        stall_pct = 0;
        hold_go   = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // step left at its reset value: no rotation
        send_pair(16'h7FFF, 16'h7FFF, 16'hFFFF);
        send_pair(16'h8000, 16'h8000, 16'h0000);
        send_pair(16'h8000, 16'h7FFF, 16'h0001);
        send_pair(16'h0000, 16'h0000, 16'h0000);
        send_pair(16'h0001, 16'hFFFF, 16'd12345);

        // quarter turn per position walks all four quadrants
        wait_drained();
        write_step(32'h4000_0000);
        send_pair(16'h7FFF, 16'h8000, 16'd0);
        send_pair(16'h7FFF, 16'h8000, 16'd1);
        send_pair(16'h7FFF, 16'h8000, 16'd2);
        send_pair(16'h7FFF, 16'h8000, 16'd3);
        send_pair(16'h8000, 16'h8000, 16'd2);

        // eighth turn: residual on the quadrant boundary, saturation at 45 degrees
        wait_drained();
        write_step(32'h2000_0000);
        send_pair(16'h7FFF, 16'h7FFF, 16'd1);
        send_pair(16'h7FFF, 16'h7FFF, 16'd3);
        send_pair(16'h8000, 16'h8000, 16'd1);
        send_pair(16'h8000, 16'h7FFF, 16'd7);

        // all-ones step, angle product wraps
        wait_drained();
        write_step(32'hFFFF_FFFF);
        send_pair(16'h7FFF, 16'h8000, 16'hFFFF);
        send_pair(16'h8000, 16'h8000, 16'd1);
        send_pair(16'h7FFF, 16'h7FFF, 16'h8000);

        // residual just under the boundary
        wait_drained();
        write_step(32'h1FFF_FFFF);
        send_pair(16'h7FFF, 16'h7FFF, 16'd1);

        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            idle_pct  = idle_tab[p];
            stall_pct = stall_tab[p];
            case (p)
                1: step = $urandom_range(32'h0010_0000, 1);
                2: step = 32'hFFFF_FFFF;
                default: step = $urandom;
            endcase
            write_step(step);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // back-pressure: hold the output and keep offering pairs
                if (p == 0 && n == 60)
                    hold_go = 1'b1;
                if (p == 0 && n == 110)
                    wait_drained();
                send_pair(pick_component(), pick_component(), pick_position());
            end
        end

        wait_drained();
        repeat (rvr_pkg::CORDIC_STAGES + 8) @(posedge clk);
        if (outstanding != 0)
            $error("%0d expected results never arrived", outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
